/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared property shorthands for the queue buffer rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet while reset is held
`define MQSB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// next-cycle implication, quiet while reset is held
`define MQSB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

/* src/mqsb_pkg.sv */
// ----------------------------------------------------------------------------
// mqsb_pkg
// constants, types and helpers of the multi-queue shared buffer
// ----------------------------------------------------------------------------
package mqsb_pkg;

    localparam int SLOTS  = 16;
    localparam int QUEUES = 4;
    localparam int DATA_W = 32;
    localparam int QID_IN_W = 2;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LINK_W = $clog2(SLOTS + 1);
    localparam int QID_W  = (QUEUES > 1) ? $clog2(QUEUES) : 1;

    localparam logic [LINK_W-1:0] NIL = LINK_W'(SLOTS);

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        FSM_INIT = 3'b001,
        FSM_IDLE = 3'b010,
        FSM_EXEC = 3'b100
    } fsm_t;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] addr;
        logic [LINK_W-1:0] data;
    } link_wr_t;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } data_wr_t;

    typedef struct packed {
        logic              re;
        logic [SLOT_W-1:0] addr;
    } ram_rd_t;

    typedef struct packed {
        status_t           status;
        logic [DATA_W-1:0] pop_data;
    } result_t;

    function automatic logic is_slot(input logic [LINK_W-1:0] l);
        return l < NIL;
    endfunction

    // corrupt links read as null
    function automatic logic [LINK_W-1:0] norm_link(input logic [LINK_W-1:0] l);
        return is_slot(l) ? l : NIL;
    endfunction

    function automatic logic [SLOT_W-1:0] link_to_slot(input logic [LINK_W-1:0] l);
        return SLOT_W'(l);
    endfunction

    function automatic logic [LINK_W-1:0] slot_to_link(input logic [SLOT_W-1:0] s);
        return LINK_W'(s);
    endfunction

    function automatic logic [LINK_W-1:0] next_link(input logic [SLOT_W-1:0] s);
        return LINK_W'(s) + LINK_W'(1);
    endfunction

    function automatic logic is_last_slot(input logic [SLOT_W-1:0] s);
        return s == SLOT_W'(SLOTS - 1);
    endfunction

    function automatic logic q_in_range(input logic [QID_IN_W-1:0] q);
        return int'(q) < QUEUES;
    endfunction

    function automatic logic [QID_W-1:0] qid_of(input logic [QID_IN_W-1:0] q);
        return QID_W'(q);
    endfunction

endpackage

/* src/mqsb_ram.sv */
// ----------------------------------------------------------------------------
// mqsb_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module mqsb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/mqsb_engine.sv */
// ----------------------------------------------------------------------------
// mqsb_engine
// sequencer for push and pop: queue pointers, free list and ram accesses
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mqsb_engine (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic                                cmd,
    input  logic [mqsb_pkg::QID_IN_W-1:0]       queue_id,
    input  logic [mqsb_pkg::DATA_W-1:0]         push_data,
    input  logic                                out_free,
    output mqsb_pkg::link_wr_t                  link_wr,
    output mqsb_pkg::ram_rd_t                   link_rd,
    input  logic [mqsb_pkg::LINK_W-1:0]         link_rdata,
    output mqsb_pkg::data_wr_t                  data_wr,
    output mqsb_pkg::ram_rd_t                   data_rd,
    input  logic [mqsb_pkg::DATA_W-1:0]         data_rdata,
    output logic                                res_valid,
    output mqsb_pkg::result_t                   res
);

    mqsb_pkg::fsm_t                    state_reg, state_next;
    logic [mqsb_pkg::SLOT_W-1:0]       init_cnt_reg;
    logic [mqsb_pkg::LINK_W-1:0]       head_reg [mqsb_pkg::QUEUES];
    logic [mqsb_pkg::SLOT_W-1:0]       tail_reg [mqsb_pkg::QUEUES];
    logic [mqsb_pkg::LINK_W-1:0]       free_head_reg;
    logic                              cmd_reg;
    logic [mqsb_pkg::QID_W-1:0]        q_idx_reg;
    logic [mqsb_pkg::SLOT_W-1:0]       slot_reg;
    logic                              fail_reg;

    logic                              acc;
    logic                              exec_go;
    logic [mqsb_pkg::QID_W-1:0]        q_idx;
    logic [mqsb_pkg::LINK_W-1:0]       cand;
    logic                              ok;
    logic                              head_live;

    assign s_tready  = (state_reg == mqsb_pkg::FSM_IDLE);
    assign acc       = s_tvalid && s_tready;
    assign exec_go   = (state_reg == mqsb_pkg::FSM_EXEC) && out_free;
    assign q_idx     = mqsb_pkg::qid_of(queue_id);
    assign head_live = mqsb_pkg::is_slot(head_reg[q_idx]);
    // push takes the free-list head, pop the queue head
    assign cand      = (cmd == mqsb_pkg::CMD_PUSH) ? free_head_reg : head_reg[q_idx];
    assign ok        = mqsb_pkg::q_in_range(queue_id) && mqsb_pkg::is_slot(cand);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mqsb_pkg::FSM_INIT: begin
                if (mqsb_pkg::is_last_slot(init_cnt_reg)) begin
                    state_next = mqsb_pkg::FSM_IDLE;
                end
            end
            mqsb_pkg::FSM_IDLE: begin
                if (acc) begin
                    state_next = mqsb_pkg::FSM_EXEC;
                end
            end
            mqsb_pkg::FSM_EXEC: begin
                if (out_free) begin
                    state_next = mqsb_pkg::FSM_IDLE;
                end
            end
            default: state_next = mqsb_pkg::FSM_INIT;
        endcase
    end

    // link ram: clearing pass, tail relink on accept, slot relink on exec
    always_comb begin
        link_wr.we   = 1'b0;
        link_wr.addr = slot_reg;
        link_wr.data = mqsb_pkg::NIL;
        if (state_reg == mqsb_pkg::FSM_INIT) begin
            link_wr.we   = 1'b1;
            link_wr.addr = init_cnt_reg;
            link_wr.data = mqsb_pkg::next_link(init_cnt_reg);
        end else if (acc && ok && cmd == mqsb_pkg::CMD_PUSH && head_live) begin
            link_wr.we   = 1'b1;
            link_wr.addr = tail_reg[q_idx];
            link_wr.data = free_head_reg;
        end else if (exec_go && !fail_reg) begin
            link_wr.we   = 1'b1;
            link_wr.addr = slot_reg;
            link_wr.data = (cmd_reg == mqsb_pkg::CMD_PUSH) ? mqsb_pkg::NIL : free_head_reg;
        end
    end

    assign link_rd.re   = acc && ok;
    assign link_rd.addr = mqsb_pkg::link_to_slot(cand);

    assign data_wr.we   = acc && ok && (cmd == mqsb_pkg::CMD_PUSH);
    assign data_wr.addr = mqsb_pkg::link_to_slot(cand);
    assign data_wr.data = push_data;

    assign data_rd.re   = acc && ok && (cmd == mqsb_pkg::CMD_POP);
    assign data_rd.addr = mqsb_pkg::link_to_slot(cand);

    assign res_valid = exec_go;

    always_comb begin
        if (fail_reg) begin
            res.status = (cmd_reg == mqsb_pkg::CMD_PUSH) ? mqsb_pkg::ST_FULL
                                                         : mqsb_pkg::ST_EMPTY;
        end else begin
            res.status = mqsb_pkg::ST_OK;
        end
        res.pop_data = (!fail_reg && cmd_reg == mqsb_pkg::CMD_POP) ? data_rdata
                                                                   : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mqsb_pkg::FSM_INIT;
            init_cnt_reg  <= '0;
            free_head_reg <= '0;
            for (int i = 0; i < mqsb_pkg::QUEUES; i++) begin
                head_reg[i] <= mqsb_pkg::NIL;
            end
        end else begin
            state_reg <= state_next;
            if (state_reg == mqsb_pkg::FSM_INIT) begin
                init_cnt_reg <= init_cnt_reg + mqsb_pkg::SLOT_W'(1);
            end
            if (acc && ok && cmd == mqsb_pkg::CMD_PUSH && !head_live) begin
                head_reg[q_idx] <= cand;
            end
            if (exec_go && !fail_reg) begin
                if (cmd_reg == mqsb_pkg::CMD_PUSH) begin
                    free_head_reg <= mqsb_pkg::norm_link(link_rdata);
                end else begin
                    head_reg[q_idx_reg] <= mqsb_pkg::norm_link(link_rdata);
                    free_head_reg       <= mqsb_pkg::slot_to_link(slot_reg);
                end
            end
        end
    end

    // item context and tails, no reset needed
    always_ff @(posedge aclk) begin
        if (acc) begin
            cmd_reg   <= cmd;
            q_idx_reg <= q_idx;
            slot_reg  <= mqsb_pkg::link_to_slot(cand);
            fail_reg  <= !ok;
            if (ok && cmd == mqsb_pkg::CMD_PUSH) begin
                tail_reg[q_idx] <= mqsb_pkg::link_to_slot(cand);
            end
        end
    end

    `MQSB_ASSERT_NXT(a_accept_to_exec, aclk, aresetn, acc, state_reg == mqsb_pkg::FSM_EXEC)
    `MQSB_ASSERT_NXT(a_push_head_live, aclk, aresetn,
        exec_go && !fail_reg && cmd_reg == mqsb_pkg::CMD_PUSH,
        mqsb_pkg::is_slot(head_reg[q_idx_reg]))
    `MQSB_ASSERT_NXT(a_pop_frees_slot, aclk, aresetn,
        exec_go && !fail_reg && cmd_reg == mqsb_pkg::CMD_POP,
        free_head_reg == mqsb_pkg::slot_to_link(slot_reg))

endmodule

/* src/multi_queue_shared_buffer_top.sv */
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer_top
// several fifo queues kept as linked lists in one shared slot store
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one item is one command. s_tuser[0] is cmd (0 push, 1 pop),
//   s_tuser[2:1] is queue_id, s_tdata is the word pushed (ignored on pop)
//   m_ channel: exactly one result item per command, in command order.
//   m_tuser is status (0 ok, 1 push rejected, no free slot, 2 pop of an
//   empty queue), m_tdata is the popped word, zero otherwise
//   completion: an accepted command enters the exec state, and its result
//   is loaded into the output register once that register is free; a new
//   command is accepted only after the previous one completes. Each reads
//   the link ram (and data ram on pop) on accept and writes its link in exec
//   reset: after aresetn is released a clearing pass over all SLOTS slots
//   chains every slot on the free list; s_tready stays low meanwhile
//   stall: a result waits in the output register while m_tready is low; the
//   next command is still accepted, and its completion waits for the
//   output register to drain
// ----------------------------------------------------------------------------
module multi_queue_shared_buffer_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] push_data
    input  logic [2:0]  s_tuser,    // [0] cmd, [2:1] queue_id
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] pop_data
    output logic [1:0]  m_tuser     // [1:0] status
);

    mqsb_pkg::link_wr_t                link_wr;
    mqsb_pkg::ram_rd_t                 link_rd;
    mqsb_pkg::data_wr_t                data_wr;
    mqsb_pkg::ram_rd_t                 data_rd;
    logic [mqsb_pkg::LINK_W-1:0]       link_rdata;
    logic [mqsb_pkg::DATA_W-1:0]       data_rdata;
    logic                              res_valid;
    mqsb_pkg::result_t                 res;
    logic                              out_free;

    // output register decouples the result side
    logic                              m_tvalid_reg;
    mqsb_pkg::result_t                 m_res_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    // next-slot links, the free list and all queues live here
    mqsb_ram #(
        .WIDTH (mqsb_pkg::LINK_W),
        .DEPTH (mqsb_pkg::SLOTS)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (link_wr.we),
        .waddr (link_wr.addr),
        .wdata (link_wr.data),
        .re    (link_rd.re),
        .raddr (link_rd.addr),
        .rdata (link_rdata)
    );

    // payload words, written on push and read on pop
    mqsb_ram #(
        .WIDTH (mqsb_pkg::DATA_W),
        .DEPTH (mqsb_pkg::SLOTS)
    ) u_data_ram (
        .aclk  (aclk),
        .we    (data_wr.we),
        .waddr (data_wr.addr),
        .wdata (data_wr.data),
        .re    (data_rd.re),
        .raddr (data_rd.addr),
        .rdata (data_rdata)
    );

    mqsb_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .cmd        (s_tuser[0]),
        .queue_id   (s_tuser[2:1]),
        .push_data  (s_tdata),
        .out_free   (out_free),
        .link_wr    (link_wr),
        .link_rd    (link_rd),
        .link_rdata (link_rdata),
        .data_wr    (data_wr),
        .data_rd    (data_rd),
        .data_rdata (data_rdata),
        .res_valid  (res_valid),
        .res        (res)
    );

    // result register: load on completion, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_res_reg.pop_data;
    assign m_tuser  = m_res_reg.status;

endmodule
